// ===== hdl/lfk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared widths, word types and register codes of the leg kinematics unit
package lfk_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 32;
  localparam int TWIST_BITS = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int TRIG_W     = 18;
  localparam int TRIG_FRAC  = 16;
  localparam int TRIG_LAT   = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_OFFSET   = 3'd0,
    REG_LINK_TWO      = 3'd1,
    REG_LINK_THREE    = 3'd2,
    REG_LINK_FOUR     = 3'd3,
    REG_LINK_FIVE     = 3'd4,
    REG_TWIST_TWO     = 3'd5,
    REG_TWIST_THREE   = 3'd6,
    REG_MIRROR_SELECT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] hip_yaw_angle;
    logic signed [ANGLE_BITS-1:0] hip_roll_angle;
    logic signed [ANGLE_BITS-1:0] hip_pitch_angle;
    logic signed [ANGLE_BITS-1:0] knee_pitch_angle;
  } lfk_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] foot_x;
    logic signed [COORD_BITS-1:0] foot_y;
    logic signed [COORD_BITS-1:0] foot_z;
  } lfk_out_t;

endpackage
`default_nettype wire

// ===== hdl/lfk_trig.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined fixed-point sine and cosine of one angle, Q16 results
module lfk_trig #(
  parameter int ANGLE_W = lfk_pkg::ANGLE_BITS
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ANGLE_W-1:0]                angle,
  output logic signed [lfk_pkg::TRIG_W-1:0] sin_q,
  output logic signed [lfk_pkg::TRIG_W-1:0] cos_q
);
  import lfk_pkg::*;

  localparam int RA_W  = ANGLE_W - 2;
  localparam int PX_W  = RA_W + 32;
  localparam int SIN_N = 4;
  localparam int COS_N = 5;
  localparam int X_D   = 13;
  localparam int OCT_D = 16;
  localparam logic [RA_W-1:0] OCT_SPAN = RA_W'(1) << (ANGLE_W - 3);
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [30:0] ONE = 31'd1 << 30;
  localparam logic [30:0] RND = 31'd8192;
  localparam int unsigned SIN_DIV [SIN_N] = '{72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_N] = '{90, 56, 30, 12, 2};

  logic [2:0]         oct_s1_r, oct_s2_r;
  logic [RA_W-1:0]    ra_r;
  logic [ANGLE_W-4:0] low;
  logic [PX_W-1:0]    px;
  logic [29:0]        x_s2_r;
  logic [59:0]        xx;
  logic [29:0]        x_d_r  [X_D];
  logic [29:0]        x2_d_r [X_D];
  logic [2:0]         oct_d_r [OCT_D];
  logic [30:0]        sp_r [SIN_N];
  logic [30:0]        sq_r [SIN_N];
  logic [30:0]        sn_r [SIN_N];
  logic [30:0]        st_r [SIN_N];
  logic [30:0]        cp_r [COS_N];
  logic [30:0]        cq_r [COS_N];
  logic [30:0]        cn_r [COS_N];
  logic [30:0]        ct_r [COS_N];
  logic [60:0]        sm;
  logic [29:0]        sm_r, sd1_r, sd2_r;
  logic [30:0]        s_rnd, c_rnd;
  logic [TRIG_W-1:0]  s0, c0;
  logic signed [TRIG_W-1:0] sin_nxt, cos_nxt, sin_r, cos_r;

  assign low = angle[ANGLE_W-4:0];
  assign px  = PX_W'(ra_r) * PX_W'(PI_Q30);
  assign xx  = 60'(x_s2_r) * 60'(x_s2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      oct_s1_r <= angle[ANGLE_W-1 -: 3];
      ra_r     <= angle[ANGLE_W-3] ? OCT_SPAN - RA_W'(low) : RA_W'(low);
      oct_s2_r <= oct_s1_r;
      x_s2_r   <= px[ANGLE_W+28 -: 30];
      x_d_r[0]   <= x_s2_r;
      x2_d_r[0]  <= xx[59:30];
      oct_d_r[0] <= oct_s2_r;
      for (int i = 1; i < X_D; i++) begin
        x_d_r[i]  <= x_d_r[i-1];
        x2_d_r[i] <= x2_d_r[i-1];
      end
      for (int i = 1; i < OCT_D; i++) begin
        oct_d_r[i] <= oct_d_r[i-1];
      end
    end
  end

  for (genvar j = 0; j < SIN_N; j++) begin : g_sin
    localparam logic [6:0]  D = 7'(SIN_DIV[j]);
    localparam logic [31:0] M = 32'(64'd4294967296 / SIN_DIV[j]);
    logic [30:0] tin, qc;
    logic [60:0] pm;
    logic [62:0] qm;
    logic [37:0] rem;
    if (j == 0) begin : g_first
      assign tin = ONE;
    end else begin : g_next
      assign tin = st_r[j-1];
    end
    assign pm  = 61'(x2_d_r[3*j]) * 61'(tin);
    assign qm  = 63'(sp_r[j]) * 63'(M);
    assign rem = 38'(sn_r[j]) - 38'(sq_r[j]) * 38'(D);
    assign qc  = sq_r[j] + 31'(rem >= 38'(D));
    always_ff @(posedge clk) begin
      if (en) begin
        sp_r[j] <= pm[60:30];
        sn_r[j] <= sp_r[j];
        sq_r[j] <= qm[62:32];
        st_r[j] <= ONE - qc;
      end
    end
  end

  for (genvar j = 0; j < COS_N; j++) begin : g_cos
    localparam logic [6:0]  D = 7'(COS_DIV[j]);
    localparam logic [31:0] M = 32'(64'd4294967296 / COS_DIV[j]);
    logic [30:0] tin, qc;
    logic [60:0] pm;
    logic [62:0] qm;
    logic [37:0] rem;
    if (j == 0) begin : g_first
      assign tin = ONE;
    end else begin : g_next
      assign tin = ct_r[j-1];
    end
    assign pm  = 61'(x2_d_r[3*j]) * 61'(tin);
    assign qm  = 63'(cp_r[j]) * 63'(M);
    assign rem = 38'(cn_r[j]) - 38'(cq_r[j]) * 38'(D);
    assign qc  = cq_r[j] + 31'(rem >= 38'(D));
    always_ff @(posedge clk) begin
      if (en) begin
        cp_r[j] <= pm[60:30];
        cn_r[j] <= cp_r[j];
        cq_r[j] <= qm[62:32];
        ct_r[j] <= ONE - qc;
      end
    end
  end

  assign sm    = 61'(x_d_r[X_D-1]) * 61'(st_r[SIN_N-1]);
  assign s_rnd = 31'(sd2_r) + RND;
  assign c_rnd = ct_r[COS_N-1] + RND;
  assign s0    = TRIG_W'(s_rnd[30:14]);
  assign c0    = TRIG_W'(c_rnd[30:14]);

  always_comb begin
    logic signed [TRIG_W-1:0] sq, cq;
    sq = oct_d_r[OCT_D-1][0] ? c0 : s0;
    cq = oct_d_r[OCT_D-1][0] ? s0 : c0;
    unique case (oct_d_r[OCT_D-1][2:1])
      2'd0: begin sin_nxt = sq;  cos_nxt = cq;  end
      2'd1: begin sin_nxt = cq;  cos_nxt = -sq; end
      2'd2: begin sin_nxt = -sq; cos_nxt = -cq; end
      2'd3: begin sin_nxt = -cq; cos_nxt = sq;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_r  <= sm[59:30];
      sd1_r <= sm_r;
      sd2_r <= sd1_r;
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule
`default_nettype wire

// ===== hdl/leg_forward_kinematics_dh_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Leg forward kinematics: four joint angles in, foot position out.
// Input channel in_valid / in_stall / in_word carries one joint-angle word;
// output channel out_valid / out_stall / out_word carries x, y, z in Q16.16,
// saturated. A word is taken at a clock edge with valid high and stall low.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it. One
// word is taken per cycle while the output is not stalled. Nineteen stages
// compute the six sines and cosines in parallel (four joints, two twists),
// twelve apply the six rotations, one saturates into the output register.
// The whole pipeline freezes while out_valid is high and out_stall is high;
// one further input word is then taken into a skid register, after which
// in_stall rises until the output moves again.
// Synchronous reset clears the valid bits, the skid valid bit and all
// configuration registers.
module leg_forward_kinematics_dh_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lfk_pkg::lfk_in_t               in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lfk_pkg::lfk_out_t              out_word,
  input  logic                           cfg_we,
  input  logic [lfk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfk_pkg::CFG_W-1:0]      cfg_data
);
  import lfk_pkg::*;

  localparam int CW   = COORD_BITS + 8;
  localparam int PW   = CW + TRIG_W;
  localparam int NROT = 6;
  localparam int LAT  = TRIG_LAT + 2 * NROT + 1;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (TRIG_FRAC - 1);
  localparam logic signed [CW-1:0] SAT_HI = CW'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  logic signed [31:0]     base_offset_r, link_two_r, link_three_r, link_four_r, link_five_r;
  logic [TWIST_BITS-1:0]  twist_two_r, twist_three_r;
  logic                   mirror_r;
  logic                   skid_v_r, skid_v_nxt;
  lfk_in_t                skid_r, front_word;
  logic                   front_valid, en;
  logic [LAT-1:0]         vld_r;
  lfk_out_t               out_word_r;
  logic [ANGLE_BITS-1:0]  roll_adj;
  trig_t                  tq [NROT];
  logic signed [CW-1:0]   pac_r [NROT];
  logic signed [CW-1:0]   pbs_r [NROT];
  logic signed [CW-1:0]   pas_r [NROT];
  logic signed [CW-1:0]   pbc_r [NROT];
  logic signed [CW-1:0]   keep_r [NROT];
  logic signed [CW-1:0]   cx_r [NROT];
  logic signed [CW-1:0]   cy_r [NROT];
  logic signed [CW-1:0]   cz_r [NROT];

  function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] v,
                                                input logic signed [TRIG_W-1:0] f);
    logic signed [PW-1:0] pr;
    pr = PW'(v) * PW'(f) + ROUND_HALF;
    return pr[CW+TRIG_FRAC-1:TRIG_FRAC];
  endfunction

  function automatic logic [COORD_BITS-1:0] sat(input logic signed [CW-1:0] v);
    logic [COORD_BITS-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[COORD_BITS-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[COORD_BITS-1:0];
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_offset_r <= '0;
      link_two_r    <= '0;
      link_three_r  <= '0;
      link_four_r   <= '0;
      link_five_r   <= '0;
      twist_two_r   <= '0;
      twist_three_r <= '0;
      mirror_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_OFFSET:   base_offset_r <= cfg_data;
        REG_LINK_TWO:      link_two_r    <= cfg_data;
        REG_LINK_THREE:    link_three_r  <= cfg_data;
        REG_LINK_FOUR:     link_four_r   <= cfg_data;
        REG_LINK_FIVE:     link_five_r   <= cfg_data;
        REG_TWIST_TWO:     twist_two_r   <= cfg_data[TWIST_BITS-1:0];
        REG_TWIST_THREE:   twist_three_r <= cfg_data[TWIST_BITS-1:0];
        REG_MIRROR_SELECT: mirror_r      <= cfg_data[0];
      endcase
    end
  end

  // advance whenever the output word is free or being taken
  assign en          = !vld_r[LAT-1] || !out_stall;
  assign front_valid = skid_v_r || in_valid;
  assign front_word  = skid_v_r ? skid_r : in_word;
  assign in_stall    = skid_v_r;
  assign roll_adj    = mirror_r ? front_word.hip_roll_angle - QUARTER
                                : front_word.hip_roll_angle + QUARTER;

  always_comb begin
    skid_v_nxt = en ? 1'b0 : (skid_v_r || in_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      skid_v_r <= skid_v_nxt;
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], front_valid};
      end
    end
  end

  // hold the word that arrives while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (!en && !skid_v_r) begin
      skid_r <= in_word;
    end
  end

  for (genvar k = 0; k < NROT; k++) begin : g_rot
    localparam bit IsX = (k == 2) || (k == 4);
    trig_t tv;
    logic signed [CW-1:0] ix, iy, iz, a, b, keep, lk, na, nb;

    if (IsX) begin : g_twist
      lfk_trig #(.ANGLE_W(TWIST_BITS)) u_trig (
        .clk   (clk),
        .en    (en),
        .angle (k == 2 ? twist_three_r : twist_two_r),
        .sin_q (tq[k].s),
        .cos_q (tq[k].c)
      );
    end else begin : g_joint
      logic [ANGLE_BITS-1:0] ja;
      if (k == 0) begin : g_knee
        assign ja = front_word.knee_pitch_angle;
      end else if (k == 1) begin : g_pitch
        assign ja = front_word.hip_pitch_angle;
      end else if (k == 3) begin : g_roll
        assign ja = roll_adj;
      end else begin : g_yaw
        assign ja = front_word.hip_yaw_angle;
      end
      lfk_trig #(.ANGLE_W(ANGLE_BITS)) u_trig (
        .clk   (clk),
        .en    (en),
        .angle (ja),
        .sin_q (tq[k].s),
        .cos_q (tq[k].c)
      );
    end

    if (k == 0) begin : g_head
      assign tv = tq[k];
      assign ix = CW'(link_five_r);
      assign iy = '0;
      assign iz = '0;
    end else begin : g_chain
      trig_t dl_r [2*k];
      always_ff @(posedge clk) begin
        if (en) begin
          dl_r[0] <= tq[k];
          for (int i = 1; i < 2 * k; i++) begin
            dl_r[i] <= dl_r[i-1];
          end
        end
      end
      assign tv = dl_r[2*k-1];
      assign ix = cx_r[k-1];
      assign iy = cy_r[k-1];
      assign iz = cz_r[k-1];
    end

    assign lk = (k == 0) ? CW'(link_four_r)
              : (k == 2) ? CW'(link_three_r)
              : (k == 4) ? CW'(link_two_r)
              : (k == 5) ? CW'(base_offset_r)
              : '0;
    assign a    = IsX ? iy : ix;
    assign b    = IsX ? iz : iy;
    assign keep = IsX ? ix : iz;
    assign na   = pac_r[k] - pbs_r[k];
    assign nb   = pas_r[k] + pbc_r[k];

    always_ff @(posedge clk) begin
      if (en) begin
        pac_r[k]  <= mulq(a, tv.c);
        pbs_r[k]  <= mulq(b, tv.s);
        pas_r[k]  <= mulq(a, tv.s);
        pbc_r[k]  <= mulq(b, tv.c);
        keep_r[k] <= keep;
        if (IsX) begin
          cx_r[k] <= keep_r[k] + lk;
          cy_r[k] <= na;
          cz_r[k] <= nb;
        end else begin
          cx_r[k] <= na + lk;
          cy_r[k] <= nb;
          cz_r[k] <= keep_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r.foot_x <= sat(cx_r[NROT-1]);
      out_word_r.foot_y <= sat(cy_r[NROT-1]);
      out_word_r.foot_z <= sat(cz_r[NROT-1]);
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// ===== hdl/lfk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks of the leg kinematics unit, bound to the top level
module lfk_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input lfk_pkg::lfk_out_t out_word
);
  import lfk_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed or dropped");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no output word waiting");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled output");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid or stall survived reset");

endmodule

bind leg_forward_kinematics_dh_unit lfk_port_checker u_lfk_checker (.*);
`default_nettype wire
